@@ hdl/hsvbo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_pkg
// Types and constants shared by the HSV band occupancy feature store.
// ----------------------------------------------------------------------------
package hsvbo_pkg;

   localparam int CNT_W        = 10;
   localparam int BAND_W       = 9;
   localparam int PIX_W        = 8;
   localparam int WORD_W       = 64;
   localparam int BIT_SEL_W    = 6;
   localparam int WORD_INDEX_W = 8;
   localparam int CMD_W        = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 10;

   localparam logic [PIX_W-1:0] HUE_RANGE = 8'd180;

   localparam logic [CNT_W-1:0]  IMAGE_WIDTH_RESET = 10'd250;
   localparam logic [CNT_W-1:0]  BLOCK_SIZE_RESET  = 10'd250;
   localparam logic [BAND_W-1:0] HUE_WIDTH_RESET   = 9'd18;
   localparam logic [BAND_W-1:0] HUE_COUNT_RESET   = 9'd10;
   localparam logic [BAND_W-1:0] SAT_WIDTH_RESET   = 9'd26;
   localparam logic [BAND_W-1:0] SAT_COUNT_RESET   = 9'd10;
   localparam logic [BAND_W-1:0] VAL_WIDTH_RESET   = 9'd26;
   localparam logic [BAND_W-1:0] VAL_COUNT_RESET   = 9'd10;

   typedef enum logic [CMD_W-1:0] {
      CMD_PIXEL = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_BLOCK_SIZE     = 3'd1,
      CSR_HUE_BAND_WIDTH = 3'd2,
      CSR_HUE_BAND_COUNT = 3'd3,
      CSR_SAT_BAND_WIDTH = 3'd4,
      CSR_SAT_BAND_COUNT = 3'd5,
      CSR_VAL_BAND_WIDTH = 3'd6,
      CSR_VAL_BAND_COUNT = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MAC_BLOCK = 2'd0,
      MAC_HUE   = 2'd1,
      MAC_SAT   = 2'd2,
      MAC_VAL   = 2'd3
   } mac_sel_type;

   typedef enum logic [2:0] {
      ST_CLEAR      = 3'd0,
      ST_IDLE       = 3'd1,
      ST_DIV        = 3'd2,
      ST_MAC_SAT    = 3'd3,
      ST_MAC_VAL    = 3'd4,
      ST_MARK_READ  = 3'd5,
      ST_MARK_WRITE = 3'd6,
      ST_REPLY      = 3'd7
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  image_width;
      logic [CNT_W-1:0]  block_size;
      logic [BAND_W-1:0] hue_band_width;
      logic [BAND_W-1:0] hue_band_count;
      logic [BAND_W-1:0] sat_band_width;
      logic [BAND_W-1:0] sat_band_count;
      logic [BAND_W-1:0] val_band_width;
      logic [BAND_W-1:0] val_band_count;
   } cfg_type;

   typedef struct packed {
      logic        load_pixel;
      logic        load_read;
      logic        start_clear;
      logic        sweep;
      logic        mac_en;
      mac_sel_type mac_sel;
      logic        mark_read;
      logic        mark_write;
      logic        reply;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sweep_last;
      logic rsp_busy;
   } dp_status_type;

endpackage
`default_nettype wire

@@ hdl/hsvbo_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_if
// Valid/ready channels of the feature store: request, response, CSR write.
// ----------------------------------------------------------------------------
interface hsvbo_req_if import hsvbo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [PIX_W-1:0]        hue;
   logic [PIX_W-1:0]        sat;
   logic [PIX_W-1:0]        val;
   logic [WORD_INDEX_W-1:0] word_index;

   modport source (output valid, cmd, hue, sat, val, word_index, input ready);
   modport sink   (input valid, cmd, hue, sat, val, word_index, output ready);
endinterface

interface hsvbo_rsp_if import hsvbo_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] feature_word;
   logic              overflow;

   modport source (output valid, feature_word, overflow, input ready);
   modport sink   (input valid, feature_word, overflow, output ready);
endinterface

interface hsvbo_csr_if import hsvbo_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/hsv_band_occupancy_features.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_band_occupancy_features
// HSV band occupancy feature store, top level.
//
// req_ch carries one command word: a pixel (hue, sat, val) in raster order,
// a read of one 64-bit feature word, or a clear. rsp_ch returns one word,
// feature bits plus the sticky overflow flag, for each read only. csr_ch
// writes the geometry and band registers; it is always ready, and the user
// must write it only while the block is idle: the block does not enforce it.
// A pixel occupies the block: accept, which forms the block index in the
// shared index multiply-add, the radix-4 band dividers, the hue, sat and val
// bands through the multiply-add, then a read-modify-write of the store word.
// A read loads the response register once rsp_ch is free; a stalled receiver
// holds the response register and the block waits with ready low before it
// replies again. Reset and the clear command start a sweep that zeroes the
// store, one word a cycle, with ready low; CSR writes are still taken.
// ----------------------------------------------------------------------------
module hsv_band_occupancy_features import hsvbo_pkg::*; #(
   parameter int FEATURE_WORDS = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hsvbo_req_if.sink   req_ch,
   hsvbo_rsp_if.source rsp_ch,
   hsvbo_csr_if.sink   csr_ch
);

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   hsvbo_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .csr_ready (csr_ch.ready),
      .cfg       (cfg)
   );

   hsvbo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .status    (dp_status),
      .req_ready (req_ch.ready),
      .cmd       (dp_cmd)
   );

   hsvbo_datapath #(
      .FEATURE_WORDS (FEATURE_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_hue          (req_ch.hue),
      .req_sat          (req_ch.sat),
      .req_val          (req_ch.val),
      .req_word_index   (req_ch.word_index),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_feature_word (rsp_ch.feature_word),
      .rsp_overflow     (rsp_ch.overflow)
   );

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !dp_cmd.sweep)
      else $error("request accepted during store sweep");

   a_reply_slot_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.reply |-> !dp_status.rsp_busy)
      else $error("response overwritten while stalled");

   a_read_holds_ready: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.cmd == CMD_READ)) |=> !req_ch.ready)
      else $error("new request taken before read reply");

   a_sweep_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.sweep && dp_status.sweep_last) |=> req_ch.ready)
      else $error("block not ready after store sweep");

endmodule
`default_nettype wire

@@ hdl/hsvbo_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsvbo_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hdl/hsvbo_band_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_band_unit
// Band lookup: radix-4 restoring divide, clamp to last band.
// ----------------------------------------------------------------------------
module hsvbo_band_unit import hsvbo_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PIX_W-1:0]  value,
   input  wire logic [BAND_W-1:0] band_width,
   input  wire logic [BAND_W-1:0] band_count,
   output logic                   done,
   output logic      [BAND_W-1:0] band
);

   logic [BAND_W-1:0] rem_ff, rem_in;
   logic [PIX_W-1:0]  quo_ff, quo_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [BAND_W-1:0] rem_a, rem_b;
   logic              q_a, q_b;
   logic [BAND_W-1:0] count_m1;
   logic [BAND_W-1:0] quo_ext;

   function automatic logic [BAND_W:0] div_step(input logic [BAND_W-1:0] rem,
                                                input logic              bit_in,
                                                input logic [BAND_W-1:0] d);
      logic [BAND_W:0] t;
      logic [BAND_W:0] diff;
      logic            q;
      t    = {rem, bit_in};
      diff = t - {1'b0, d};
      q    = (t >= {1'b0, d});
      div_step = q ? {diff[BAND_W-1:0], 1'b1} : {t[BAND_W-1:0], 1'b0};
   endfunction

   always_comb begin
      {rem_a, q_a} = div_step(rem_ff, quo_ff[PIX_W-1], band_width);
      {rem_b, q_b} = div_step(rem_a, quo_ff[PIX_W-2], band_width);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = value;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = rem_b;
         quo_in  = {quo_ff[PIX_W-3:0], q_a, q_b};
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   // clamp to the last band; zero width maps everything there
   always_comb begin
      count_m1 = band_count - BAND_W'(1);
      quo_ext  = BAND_W'(quo_ff);
      band     = ((band_width == '0) || (quo_ext > count_m1)) ? count_m1 : quo_ext;
   end

   assign done = !busy_ff;

endmodule
`default_nettype wire

@@ hdl/hsvbo_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_regs
// Configuration register file written through the CSR channel.
// ----------------------------------------------------------------------------
module hsvbo_regs import hsvbo_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        csr_ready,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:    cfg_in.image_width    = csr_data;
            CSR_BLOCK_SIZE:     cfg_in.block_size     = csr_data;
            CSR_HUE_BAND_WIDTH: cfg_in.hue_band_width = csr_data[BAND_W-1:0];
            CSR_HUE_BAND_COUNT: cfg_in.hue_band_count = csr_data[BAND_W-1:0];
            CSR_SAT_BAND_WIDTH: cfg_in.sat_band_width = csr_data[BAND_W-1:0];
            CSR_SAT_BAND_COUNT: cfg_in.sat_band_count = csr_data[BAND_W-1:0];
            CSR_VAL_BAND_WIDTH: cfg_in.val_band_width = csr_data[BAND_W-1:0];
            CSR_VAL_BAND_COUNT: cfg_in.val_band_count = csr_data[BAND_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= IMAGE_WIDTH_RESET;
         cfg_ff.block_size     <= BLOCK_SIZE_RESET;
         cfg_ff.hue_band_width <= HUE_WIDTH_RESET;
         cfg_ff.hue_band_count <= HUE_COUNT_RESET;
         cfg_ff.sat_band_width <= SAT_WIDTH_RESET;
         cfg_ff.sat_band_count <= SAT_COUNT_RESET;
         cfg_ff.val_band_width <= VAL_WIDTH_RESET;
         cfg_ff.val_band_count <= VAL_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/hsvbo_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_ctrl
// Sequencer: store sweep, pixel band/index/mark steps, word read and reply.
// ----------------------------------------------------------------------------
module hsvbo_ctrl import hsvbo_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_cmd,
   input  wire dp_status_type    status,
   output logic                  req_ready,
   output dp_cmd_type            cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (cmd_type'(req_cmd))
                  CMD_PIXEL: begin
                     cmd.load_pixel = 1'b1;
                     cmd.mac_en     = 1'b1;
                     cmd.mac_sel    = MAC_BLOCK;
                     state_in       = ST_DIV;
                  end
                  CMD_READ: begin
                     cmd.load_read = 1'b1;
                     state_in      = ST_REPLY;
                  end
                  CMD_CLEAR: begin
                     cmd.start_clear = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  CMD_NONE: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.mac_en  = 1'b1;
               cmd.mac_sel = MAC_HUE;
               state_in    = ST_MAC_SAT;
            end
         end
         ST_MAC_SAT: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_SAT;
            state_in    = ST_MAC_VAL;
         end
         ST_MAC_VAL: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_VAL;
            state_in    = ST_MARK_READ;
         end
         ST_MARK_READ: begin
            cmd.mark_read = 1'b1;
            state_in      = ST_MARK_WRITE;
         end
         ST_MARK_WRITE: begin
            cmd.mark_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_REPLY: begin
            if (!status.rsp_busy) begin
               cmd.reply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/hsvbo_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvbo_datapath
// Raster counters, band units, saturating index multiply-add, occupancy
// store and response register.
// ----------------------------------------------------------------------------
module hsvbo_datapath import hsvbo_pkg::*; #(
   parameter int FEATURE_WORDS = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire dp_cmd_type              cmd,
   output dp_status_type                status,
   input  wire logic [PIX_W-1:0]        req_hue,
   input  wire logic [PIX_W-1:0]        req_sat,
   input  wire logic [PIX_W-1:0]        req_val,
   input  wire logic [WORD_INDEX_W-1:0] req_word_index,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic      [WORD_W-1:0]       rsp_feature_word,
   output logic                         rsp_overflow
);

   localparam int AW   = $clog2(FEATURE_WORDS);
   localparam int CAP  = FEATURE_WORDS * WORD_W;
   localparam int CW   = $clog2(CAP + 1);
   localparam int PW   = CW + CNT_W + 1;
   localparam int RI_W = (AW + 1 > WORD_INDEX_W) ? AW + 1 : WORD_INDEX_W;

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] column_in_block_ff, column_in_block_in;
   logic [CNT_W-1:0] block_column_ff, block_column_in;
   logic [CNT_W-1:0] blocks_per_row_ff, blocks_per_row_in;
   logic [CNT_W-1:0] row_in_block_ff, row_in_block_in;
   logic [CNT_W-1:0] block_row_ff, block_row_in;
   logic             overflow_ff, overflow_in;
   logic             skip_ff, skip_in;
   logic             in_range_ff, in_range_in;
   logic [CW-1:0]    acc_ff, acc_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [CNT_W-1:0] column_next, cib_next, rib_next;
   logic [BAND_W-1:0] hue_band, sat_band, val_band;
   logic             hue_done, sat_done, val_done;
   logic [CW-1:0]    mac_a;
   logic [CNT_W-1:0] mac_b, mac_c;
   logic [PW-1:0]    mac_sum;
   logic [CW-1:0]    mac_sat;
   logic             big;
   logic [AW-1:0]    word_addr;
   logic             req_in_range;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   hsvbo_band_unit u_hue_band (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.load_pixel),
      .value      (req_hue),
      .band_width (cfg.hue_band_width),
      .band_count (cfg.hue_band_count),
      .done       (hue_done),
      .band       (hue_band)
   );

   hsvbo_band_unit u_sat_band (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.load_pixel),
      .value      (req_sat),
      .band_width (cfg.sat_band_width),
      .band_count (cfg.sat_band_count),
      .done       (sat_done),
      .band       (sat_band)
   );

   hsvbo_band_unit u_val_band (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.load_pixel),
      .value      (req_val),
      .band_width (cfg.val_band_width),
      .band_count (cfg.val_band_count),
      .done       (val_done),
      .band       (val_band)
   );

   hsvbo_ram #(
      .WIDTH (WORD_W),
      .DEPTH (FEATURE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared multiply-add, saturated at store capacity
   always_comb begin
      unique case (cmd.mac_sel)
         MAC_BLOCK: begin
            mac_a = CW'(block_row_ff);
            mac_b = blocks_per_row_ff;
            mac_c = block_column_ff;
         end
         MAC_HUE: begin
            mac_a = acc_ff;
            mac_b = CNT_W'(cfg.hue_band_count);
            mac_c = CNT_W'(hue_band);
         end
         MAC_SAT: begin
            mac_a = acc_ff;
            mac_b = CNT_W'(cfg.sat_band_count);
            mac_c = CNT_W'(sat_band);
         end
         MAC_VAL: begin
            mac_a = acc_ff;
            mac_b = CNT_W'(cfg.val_band_count);
            mac_c = CNT_W'(val_band);
         end
      endcase
      mac_sum = PW'(mac_a) * PW'(mac_b) + PW'(mac_c);
      mac_sat = (mac_sum >= PW'(CAP)) ? CW'(CAP) : mac_sum[CW-1:0];
   end

   assign big          = (acc_ff == CW'(CAP));
   assign word_addr    = acc_ff[AW+BIT_SEL_W-1:BIT_SEL_W];
   assign req_in_range = (RI_W'(req_word_index) < RI_W'(FEATURE_WORDS));

   // raster counters, advance on every pixel
   always_comb begin
      column_next        = column_ff + CNT_W'(1);
      cib_next           = column_in_block_ff + CNT_W'(1);
      rib_next           = row_in_block_ff + CNT_W'(1);
      column_in          = column_ff;
      column_in_block_in = column_in_block_ff;
      block_column_in    = block_column_ff;
      blocks_per_row_in  = blocks_per_row_ff;
      row_in_block_in    = row_in_block_ff;
      block_row_in       = block_row_ff;
      if (cmd.start_clear) begin
         column_in          = '0;
         column_in_block_in = '0;
         block_column_in    = '0;
         blocks_per_row_in  = '0;
         row_in_block_in    = '0;
         block_row_in       = '0;
      end else if (cmd.load_pixel) begin
         if (column_next >= cfg.image_width) begin
            blocks_per_row_in  = block_column_ff + CNT_W'(1);
            column_in          = '0;
            column_in_block_in = '0;
            block_column_in    = '0;
            if (rib_next >= cfg.block_size) begin
               row_in_block_in = '0;
               block_row_in    = block_row_ff + CNT_W'(1);
            end else begin
               row_in_block_in = rib_next;
            end
         end else begin
            column_in = column_next;
            if (cib_next >= cfg.block_size) begin
               column_in_block_in = '0;
               block_column_in    = block_column_ff + CNT_W'(1);
            end else begin
               column_in_block_in = cib_next;
            end
         end
      end
   end

   always_comb begin
      skip_in      = skip_ff;
      in_range_in  = in_range_ff;
      acc_in       = acc_ff;
      overflow_in  = overflow_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_we       = 1'b0;
      ram_waddr    = word_addr;
      ram_wdata    = ram_rdata | (WORD_W'(1) << acc_ff[BIT_SEL_W-1:0]);
      ram_re       = 1'b0;
      ram_raddr    = word_addr;

      if (cmd.load_pixel) begin
         skip_in = (req_hue >= HUE_RANGE) || (cfg.hue_band_count == '0) ||
                   (cfg.sat_band_count == '0) || (cfg.val_band_count == '0);
      end
      if (cmd.mac_en) begin
         acc_in = mac_sat;
      end
      if (cmd.load_read) begin
         in_range_in = req_in_range;
         ram_re      = req_in_range;
         ram_raddr   = AW'(req_word_index);
      end
      if (cmd.mark_read) begin
         ram_re = !big;
      end
      if (cmd.mark_write) begin
         ram_we = !skip_ff && !big;
         if (!skip_ff && big) begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.start_clear) begin
         overflow_in = 1'b0;
         sweep_in    = '0;
      end
      if (cmd.sweep) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_ff;
         ram_wdata = '0;
         sweep_in  = sweep_ff + AW'(1);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = in_range_ff ? ram_rdata : '0;
         rsp_ovf_in   = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      skip_ff     <= skip_in;
      in_range_ff <= in_range_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (reset) begin
         column_ff          <= '0;
         column_in_block_ff <= '0;
         block_column_ff    <= '0;
         blocks_per_row_ff  <= '0;
         row_in_block_ff    <= '0;
         block_row_ff       <= '0;
         overflow_ff        <= 1'b0;
         sweep_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         column_ff          <= column_in;
         column_in_block_ff <= column_in_block_in;
         block_column_ff    <= block_column_in;
         blocks_per_row_ff  <= blocks_per_row_in;
         row_in_block_ff    <= row_in_block_in;
         block_row_ff       <= block_row_in;
         overflow_ff        <= overflow_in;
         sweep_ff           <= sweep_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   assign status.div_done   = hue_done && sat_done && val_done;
   assign status.sweep_last = (sweep_ff == AW'(FEATURE_WORDS - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_feature_word = rsp_word_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule
`default_nettype wire
